// File: hw/rtl/tsbr_pkg.sv
// Shared constants, types and lookup tables of the tile scroll byte renderer.
`timescale 1ns / 1ps

package tsbr_pkg;

  // Playfield and view geometry.
  localparam int FIELD_COLS        = 32;
  localparam int FIELD_ROWS        = 16;
  localparam int VIEW_ROWS         = 8;
  localparam int VIEW_WIDTH_PIXELS = 128;
  localparam int EDGE_HALF         = 1;
  localparam int TILE_COUNT        = 256;

  localparam int TILE_BYTES    = 8;
  localparam int TILE_SHIFT    = 3;
  localparam int FIELD_CELLS   = FIELD_COLS * FIELD_ROWS;
  localparam int PATTERN_BYTES = TILE_COUNT * TILE_BYTES;

  localparam int COL_W   = $clog2(FIELD_COLS);
  localparam int ROW_W   = $clog2(FIELD_ROWS);
  localparam int CELL_AW = $clog2(FIELD_CELLS);
  localparam int TILE_W  = $clog2(TILE_COUNT);
  localparam int PAT_AW  = TILE_W + TILE_SHIFT;

  // Tile sums before wrapping stay below 64 over the whole parameter range.
  localparam int SUM_W = 6;
  localparam int SUM_N = 1 << SUM_W;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 24;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SCROLL_X = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCROLL_Y = 1'd1;

  localparam logic [7:0] SCROLL_X_RESET = 8'd0;
  localparam logic [7:0] SCROLL_Y_RESET = 8'd232;

  typedef enum logic [1:0] {
    CMD_WRITE_CELL    = 2'd0,
    CMD_WRITE_PATTERN = 2'd1,
    CMD_RENDER        = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [10:0] address;
    logic [7:0]  data;
    logic [2:0]  page_row;
    logic [6:0]  pixel_column;
  } item_t;

  typedef struct packed {
    item_t            item;
    logic             render;
    logic [COL_W-1:0] tile_col;
    logic [ROW_W-1:0] tile_row;
    logic [ROW_W-1:0] next_row;
    logic [2:0]       byte_col;
    logic [2:0]       y_shift;
  } coord_t;

  typedef struct packed {
    logic       render;
    logic [2:0] page_row;
    logic [6:0] pixel_column;
    logic [2:0] y_shift;
  } pixel_t;

  typedef logic [COL_W-1:0]  col_lut_t  [SUM_N];
  typedef logic [ROW_W-1:0]  row_lut_t  [SUM_N];
  typedef logic [TILE_W-1:0] tile_lut_t [256];

  // Wrap tables are built with a running counter, so no division is involved.
  function automatic col_lut_t build_col_lut();
    col_lut_t lut;
    int r;
    r = 0;
    for (int i = 0; i < SUM_N; i++) begin
      lut[i] = COL_W'(r);
      r++;
      if (r == FIELD_COLS) r = 0;
    end
    return lut;
  endfunction

  function automatic row_lut_t build_row_lut();
    row_lut_t lut;
    int r;
    r = 0;
    for (int i = 0; i < SUM_N; i++) begin
      lut[i] = ROW_W'(r);
      r++;
      if (r == FIELD_ROWS) r = 0;
    end
    return lut;
  endfunction

  function automatic tile_lut_t build_tile_lut();
    tile_lut_t lut;
    int r;
    r = 0;
    for (int i = 0; i < 256; i++) begin
      lut[i] = TILE_W'(r);
      r++;
      if (r == TILE_COUNT) r = 0;
    end
    return lut;
  endfunction

  localparam col_lut_t  COL_LUT  = build_col_lut();
  localparam row_lut_t  ROW_LUT  = build_row_lut();
  localparam tile_lut_t TILE_LUT = build_tile_lut();

endpackage

// File: hw/rtl/tsbr_ram.sv
// Generic RAM with one write port and two registered read ports.
`timescale 1ns / 1ps

module tsbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// File: hw/rtl/tsbr_coord.sv
// Input register and tile coordinate stage of the tile scroll byte renderer.
`timescale 1ns / 1ps

module tsbr_coord (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [7:0]      scroll_x_i,
  input  logic [7:0]      scroll_y_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  tsbr_pkg::item_t in_item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output tsbr_pkg::coord_t out_coord_o
);

  logic             in_v_q;
  tsbr_pkg::item_t  item_q;
  logic             crd_v_q;
  tsbr_pkg::coord_t crd_q;
  tsbr_pkg::coord_t crd_d;

  logic ready_in;
  logic ready_crd;

  logic [7:0]                   pix;
  logic [tsbr_pkg::SUM_W-1:0]   col_sum;
  logic [tsbr_pkg::SUM_W-1:0]   row_sum;
  logic [tsbr_pkg::ROW_W-1:0]   tile_row;
  logic                         in_view;

  assign ready_crd  = !crd_v_q || out_ready_i;
  assign ready_in   = !in_v_q || ready_crd;
  assign in_ready_o = ready_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      crd_v_q <= 1'b0;
    end else begin
      if (ready_in)  in_v_q  <= in_valid_i;
      if (ready_crd) crd_v_q <= in_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_in)  item_q <= in_item_i;
    if (ready_crd) crd_q  <= crd_d;
  end

  // Pixel column inside the scrolled field, then whole tiles plus the edge offset.
  always_comb begin
    pix     = {1'b0, item_q.pixel_column} + {5'b0, scroll_x_i[2:0]};
    col_sum = tsbr_pkg::SUM_W'(scroll_x_i[7:3]) + tsbr_pkg::SUM_W'(tsbr_pkg::EDGE_HALF)
            + tsbr_pkg::SUM_W'(pix[7:3]);
    row_sum = tsbr_pkg::SUM_W'(scroll_y_i[7:3]) + tsbr_pkg::SUM_W'(tsbr_pkg::EDGE_HALF)
            + tsbr_pkg::SUM_W'(item_q.page_row);
    tile_row = tsbr_pkg::ROW_LUT[row_sum];
    in_view = ({1'b0, item_q.page_row} < 4'(tsbr_pkg::VIEW_ROWS))
           && ({2'b0, item_q.pixel_column} < 9'(tsbr_pkg::VIEW_WIDTH_PIXELS));

    crd_d.item     = item_q;
    crd_d.render   = (item_q.command == tsbr_pkg::CMD_RENDER) && in_view;
    crd_d.tile_col = tsbr_pkg::COL_LUT[col_sum];
    crd_d.tile_row = tile_row;
    crd_d.next_row = (tile_row == tsbr_pkg::ROW_W'(tsbr_pkg::FIELD_ROWS - 1))
                   ? '0 : tile_row + 1'b1;
    crd_d.byte_col = pix[2:0];
    crd_d.y_shift  = scroll_y_i[2:0];
  end

  assign out_valid_o = crd_v_q;
  assign out_coord_o = crd_q;

endmodule

// File: hw/rtl/tsbr_fetch.sv
// Playfield and tile pattern lookup stages of the tile scroll byte renderer.
`timescale 1ns / 1ps

module tsbr_fetch (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  tsbr_pkg::coord_t in_coord_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output tsbr_pkg::pixel_t out_pixel_o,
  output logic [7:0]       top_byte_o,
  output logic [7:0]       bottom_byte_o
);

  logic             cell_v_q;
  tsbr_pkg::coord_t cell_q;
  logic             pat_v_q;
  tsbr_pkg::pixel_t pat_q;

  logic ready_cell;
  logic ready_pat;

  logic                          cell_we;
  logic [tsbr_pkg::CELL_AW-1:0]  cell_addr_top;
  logic [tsbr_pkg::CELL_AW-1:0]  cell_addr_bottom;
  logic [7:0]                    top_cell;
  logic [7:0]                    bottom_cell;

  logic                          pat_we;
  logic [tsbr_pkg::PAT_AW-1:0]   pat_addr_top;
  logic [tsbr_pkg::PAT_AW-1:0]   pat_addr_bottom;

  assign ready_pat  = !pat_v_q || out_ready_i;
  assign ready_cell = !cell_v_q || ready_pat;
  assign in_ready_o = ready_cell;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_v_q <= 1'b0;
      pat_v_q  <= 1'b0;
    end else begin
      if (ready_cell) cell_v_q <= in_valid_i;
      if (ready_pat)  pat_v_q  <= cell_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_cell) cell_q <= in_coord_i;
    if (ready_pat) begin
      pat_q.render       <= cell_q.render;
      pat_q.page_row     <= cell_q.item.page_row;
      pat_q.pixel_column <= cell_q.item.pixel_column;
      pat_q.y_shift      <= cell_q.y_shift;
    end
  end

  // Each store is written at the same stage where it is read, so writes and
  // renders see the stores in stream order.
  assign cell_we = in_valid_i && ready_cell
                && (in_coord_i.item.command == tsbr_pkg::CMD_WRITE_CELL)
                && (12'(in_coord_i.item.address) < 12'(tsbr_pkg::FIELD_CELLS));

  assign cell_addr_top = tsbr_pkg::CELL_AW'(in_coord_i.tile_row)
                       * tsbr_pkg::CELL_AW'(tsbr_pkg::FIELD_COLS)
                       + tsbr_pkg::CELL_AW'(in_coord_i.tile_col);
  assign cell_addr_bottom = tsbr_pkg::CELL_AW'(in_coord_i.next_row)
                          * tsbr_pkg::CELL_AW'(tsbr_pkg::FIELD_COLS)
                          + tsbr_pkg::CELL_AW'(in_coord_i.tile_col);

  tsbr_ram #(
    .WIDTH (8),
    .DEPTH (tsbr_pkg::FIELD_CELLS)
  ) u_cells (
    .clk_i     (clk_i),
    .we_i      (cell_we),
    .waddr_i   (in_coord_i.item.address[tsbr_pkg::CELL_AW-1:0]),
    .wdata_i   (in_coord_i.item.data),
    .re_i      (ready_cell),
    .raddr_a_i (cell_addr_top),
    .raddr_b_i (cell_addr_bottom),
    .rdata_a_o (top_cell),
    .rdata_b_o (bottom_cell)
  );

  assign pat_we = cell_v_q && ready_pat
               && (cell_q.item.command == tsbr_pkg::CMD_WRITE_PATTERN)
               && (12'(cell_q.item.address) < 12'(tsbr_pkg::PATTERN_BYTES));

  assign pat_addr_top    = {tsbr_pkg::TILE_LUT[top_cell], cell_q.byte_col};
  assign pat_addr_bottom = {tsbr_pkg::TILE_LUT[bottom_cell], cell_q.byte_col};

  tsbr_ram #(
    .WIDTH (8),
    .DEPTH (tsbr_pkg::PATTERN_BYTES)
  ) u_patterns (
    .clk_i     (clk_i),
    .we_i      (pat_we),
    .waddr_i   (cell_q.item.address[tsbr_pkg::PAT_AW-1:0]),
    .wdata_i   (cell_q.item.data),
    .re_i      (ready_pat),
    .raddr_a_i (pat_addr_top),
    .raddr_b_i (pat_addr_bottom),
    .rdata_a_o (top_byte_o),
    .rdata_b_o (bottom_byte_o)
  );

  assign out_valid_o = pat_v_q;
  assign out_pixel_o = pat_q;

endmodule

// File: hw/rtl/tsbr_merge.sv
// Vertical merge and output register of the tile scroll byte renderer.
`timescale 1ns / 1ps

module tsbr_merge (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  tsbr_pkg::pixel_t                     in_pixel_i,
  input  logic [7:0]                           top_byte_i,
  input  logic [7:0]                           bottom_byte_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [tsbr_pkg::OUT_TDATA_W-1:0]     out_data_o
);

  logic                             out_v_q;
  logic [tsbr_pkg::OUT_TDATA_W-1:0] out_data_q;
  logic [tsbr_pkg::OUT_TDATA_W-1:0] out_data_d;
  logic                             slot_free;
  logic [15:0]                      pair;

  assign slot_free = !out_v_q || out_ready_i;
  // Items without a result (writes, ignored commands, renders outside the view) leave here at once.
  assign in_ready_o = !in_pixel_i.render || slot_free;

  // Shifting the two stacked bytes right gives the top byte alone when the
  // offset is zero and the merged byte otherwise.
  always_comb begin
    pair       = {bottom_byte_i, top_byte_i} >> in_pixel_i.y_shift;
    out_data_d = {6'b0, in_pixel_i.pixel_column, in_pixel_i.page_row, pair[7:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (slot_free) begin
      out_v_q <= in_valid_i && in_pixel_i.render;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_free && in_valid_i && in_pixel_i.render) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_data_q;

endmodule

// File: hw/rtl/tile_scroll_byte_renderer.sv
// Top level of the tile scroll byte renderer.
`timescale 1ns / 1ps

// The block renders a scrolling, wrap-around tile background for a page-organized
// monochrome display, one display byte (eight vertical pixels, bit 0 topmost) per
// render beat. Every input beat carries a command in tuser: write a playfield cell
// (tile index at row * FIELD_COLS + column), write a tile pattern byte (tile * 8 +
// pixel column), or render the byte at a page row and pixel column. Writes outside
// the stores, the unused command and renders outside the view give no output beat;
// every other render gives exactly one, in input order. Writes take effect in stream
// order, so a render sees every write that was accepted before it. The pipeline takes
// one beat per clock when the output side does not stall; a render result passes the
// input register, the coordinate stage, the registered playfield read, the registered
// pattern read and the output register. Backpressure stalls the stages one by one, so
// the block keeps taking beats until all five stages hold an item. The playfield and
// pattern stores hold nothing defined after reset and must be written before they are
// rendered. The user must write scroll_x and scroll_y through the configuration port
// only while the block is idle; the block itself does not enforce this.

module tile_scroll_byte_renderer (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration write port.
  input  logic                                 cfg_we_i,
  input  logic [tsbr_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [7:0]                           cfg_data_i,
  // Input stream.
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // address [10:0], data [18:11], page_row [21:19], pixel_column [28:22]
  input  logic [tsbr_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // command [1:0]
  input  logic [1:0]                           s_axis_tuser,
  // Output stream.
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // column_byte [7:0], out_row [10:8], out_column [17:11]
  output logic [tsbr_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

  logic [7:0] scroll_x_q;
  logic [7:0] scroll_y_q;

  tsbr_pkg::item_t  in_item;
  logic             crd_valid;
  logic             crd_ready;
  tsbr_pkg::coord_t crd;
  logic             pix_valid;
  logic             pix_ready;
  tsbr_pkg::pixel_t pix;
  logic [7:0]       top_byte;
  logic [7:0]       bottom_byte;

  // Scroll registers; an index beyond the list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scroll_x_q <= tsbr_pkg::SCROLL_X_RESET;
      scroll_y_q <= tsbr_pkg::SCROLL_Y_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        tsbr_pkg::REG_SCROLL_X: scroll_x_q <= cfg_data_i;
        tsbr_pkg::REG_SCROLL_Y: scroll_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    in_item.command      = s_axis_tuser;
    in_item.address      = s_axis_tdata[10:0];
    in_item.data         = s_axis_tdata[18:11];
    in_item.page_row     = s_axis_tdata[21:19];
    in_item.pixel_column = s_axis_tdata[28:22];
  end

  tsbr_coord u_coord (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .scroll_x_i  (scroll_x_q),
    .scroll_y_i  (scroll_y_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_item_i   (in_item),
    .out_valid_o (crd_valid),
    .out_ready_i (crd_ready),
    .out_coord_o (crd)
  );

  tsbr_fetch u_fetch (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (crd_valid),
    .in_ready_o    (crd_ready),
    .in_coord_i    (crd),
    .out_valid_o   (pix_valid),
    .out_ready_i   (pix_ready),
    .out_pixel_o   (pix),
    .top_byte_o    (top_byte),
    .bottom_byte_o (bottom_byte)
  );

  tsbr_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (pix_valid),
    .in_ready_o    (pix_ready),
    .in_pixel_i    (pix),
    .top_byte_i    (top_byte),
    .bottom_byte_i (bottom_byte),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_data_o    (m_axis_tdata)
  );

endmodule

// File: hw/rtl/tsbr_checker.sv
// Port-level assertions of the tile scroll byte renderer, bound to the top level.
`timescale 1ns / 1ps

module tsbr_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic [tsbr_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input logic [1:0]                        s_axis_tuser,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [tsbr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  logic [3:0] pending_q;
  logic [3:0] pending_d;
  logic       render_in;
  logic       result_out;

  // Renders inside the view that were accepted and not yet delivered.
  assign render_in = s_axis_tvalid && s_axis_tready
                  && (s_axis_tuser == tsbr_pkg::CMD_RENDER)
                  && ({1'b0, s_axis_tdata[21:19]} < 4'(tsbr_pkg::VIEW_ROWS))
                  && ({2'b0, s_axis_tdata[28:22]} < 9'(tsbr_pkg::VIEW_WIDTH_PIXELS));
  assign result_out = m_axis_tvalid && m_axis_tready;
  assign pending_d  = pending_q + 4'(render_in) - 4'(result_out);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  a_no_invented_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (pending_q != 4'd0))
    else $error("output beat without a pending render");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled while the output side is not blocked");

  a_result_in_view: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (({1'b0, m_axis_tdata[10:8]} < 4'(tsbr_pkg::VIEW_ROWS))
                   && ({2'b0, m_axis_tdata[17:11]} < 9'(tsbr_pkg::VIEW_WIDTH_PIXELS))))
    else $error("output beat for a position outside the view");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled output beat changed or vanished");

endmodule

bind tile_scroll_byte_renderer tsbr_checker u_checker (.*);

// File: sim/tb_top.sv
// Self-checking testbench for the tile scroll byte renderer.
`timescale 1ns / 1ps

// The bench drives command beats into the renderer and checks every rendered byte
// against a prediction that is built on the bench side from the scroll registers and
// from a mirror of the playfield and pattern stores.
//
// The stores are undefined after reset. The bench keeps a written flag for every
// playfield cell and every pattern byte. Before it sends a render beat, it first
// writes any cell or pattern byte that the result depends on and that has never been
// written. Those writes carry random content, so most of the stimulus is a short,
// well-formed write-then-render sequence. Random writes of both kinds, writes to cells
// past the end of the playfield and beats with the unused command are mixed in as
// noise.
//
// The run is split into phases. Each phase starts with the block idle: the sender
// stops, every pending byte has to come back, and a few more cycles pass for writes
// still in the pipeline. Then both scroll registers are written and random beats
// follow. Sender gaps and receiver stalls come in random bursts whose odds change
// per phase; the last phase has none.

module tb_top;

  import tsbr_pkg::*;

  // The command code that the block ignores.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Cycles to let a write still in flight leave the five pipeline stages.
  localparam int DRAIN_CYCLES = 8;
  // Cycles without any accepted beat on either side before the run gives up.
  localparam int QUIET_LIMIT  = 1000;
  // Beats that change state or render, per random phase.
  localparam int PHASE_BEATS  = 40;

  // One rendered byte, with the request coordinates that travel with it.
  typedef struct packed {
    logic [7:0] column_byte;
    logic [2:0] out_row;
    logic [6:0] out_column;
  } render_byte_t;

  // Mirror of the block state, byte prediction and in-order result check.
  class render_scoreboard;
    logic [7:0]   cells         [FIELD_CELLS];
    bit           cell_set      [FIELD_CELLS];
    logic [7:0]   patterns      [PATTERN_BYTES];
    bit           pattern_set   [PATTERN_BYTES];
    logic [7:0]   scroll_x;
    logic [7:0]   scroll_y;
    render_byte_t pending_bytes [$];
    int unsigned  mismatches;

    function new();
      scroll_x   = SCROLL_X_RESET;
      scroll_y   = SCROLL_Y_RESET;
      mismatches = 0;
      foreach (cell_set[i]) cell_set[i] = 1'b0;
      foreach (pattern_set[i]) pattern_set[i] = 1'b0;
    endfunction

    // Finds the playfield cells and the byte column that a render reads.
    function void locate(input logic [2:0] row, input logic [6:0] column,
                         output int top_cell, output int low_cell,
                         output int byte_col, output int y_shift);
      int sx;
      int sy;
      int cs;
      int tx;
      int ty;
      sx       = int'(scroll_x);
      sy       = int'(scroll_y);
      y_shift  = sy % TILE_BYTES;
      cs       = sx % TILE_BYTES + int'(column);
      tx       = (sx / TILE_BYTES + EDGE_HALF + cs / TILE_BYTES) % FIELD_COLS;
      ty       = (sy / TILE_BYTES + EDGE_HALF + int'(row)) % FIELD_ROWS;
      top_cell = ty * FIELD_COLS + tx;
      low_cell = ((ty + 1) % FIELD_ROWS) * FIELD_COLS + tx;
      byte_col = cs % TILE_BYTES;
    endfunction

    function int pattern_index(input int cell_idx, input int byte_col);
      return (int'(cells[cell_idx]) % TILE_COUNT) * TILE_BYTES + byte_col;
    endfunction

    // The top tile byte moves up by the fine vertical offset and the tile below
    // fills the freed bits from the bottom.
    function render_byte_t predict_byte(input item_t beat);
      render_byte_t res;
      int top;
      int low;
      int bc;
      int ys;
      int pix;
      locate(beat.page_row, beat.pixel_column, top, low, bc, ys);
      pix = int'(patterns[pattern_index(top, bc)]) >> ys;
      if (ys != 0) begin
        pix = pix | (int'(patterns[pattern_index(low, bc)]) << (TILE_BYTES - ys));
      end
      res.column_byte = 8'(pix);
      res.out_row     = beat.page_row;
      res.out_column  = beat.pixel_column;
      return res;
    endfunction

    // Applies one accepted input beat in stream order.
    function void note_beat(input item_t beat);
      case (cmd_e'(beat.command))
        CMD_WRITE_CELL: begin
          if (int'(beat.address) < FIELD_CELLS) begin
            cells[beat.address]    = beat.data;
            cell_set[beat.address] = 1'b1;
          end
        end
        CMD_WRITE_PATTERN: begin
          if (int'(beat.address) < PATTERN_BYTES) begin
            patterns[beat.address]    = beat.data;
            pattern_set[beat.address] = 1'b1;
          end
        end
        CMD_RENDER: begin
          if (int'(beat.page_row) < VIEW_ROWS &&
              int'(beat.pixel_column) < VIEW_WIDTH_PIXELS) begin
            pending_bytes.push_back(predict_byte(beat));
          end
        end
        default: begin
        end
      endcase
    endfunction

    function void check_byte(input render_byte_t got);
      render_byte_t want;
      if (pending_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected byte %h at row %0d column %0d",
                   got.column_byte, got.out_row, got.out_column);
        end
        return;
      end
      want = pending_bytes.pop_front();
      if (got.column_byte !== want.column_byte || got.out_row !== want.out_row ||
          got.out_column !== want.out_column) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("byte mismatch: expected %h row %0d column %0d, got %h row %0d column %0d",
                   want.column_byte, want.out_row, want.out_column,
                   got.column_byte, got.out_row, got.out_column);
        end
      end
    endfunction

    function bit clean();
      return mismatches == 0 && pending_bytes.size() == 0;
    endfunction
  endclass

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index_i   = '0;
  logic [7:0]             cfg_data_i    = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [1:0]             s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  render_scoreboard sb = new();

  // Burst odds: one chance in N per beat or cycle to start a gap; zero means none.
  int gap_odds    = 0;
  int stall_odds  = 0;
  int ready_hold  = 0;
  int quiet_count = 0;
  // Accepted beats that the block does not ignore.
  int live_beats  = 0;

  tile_scroll_byte_renderer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // Output side: tready drops for random bursts at the current odds.
  always @(posedge clk_i) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
      m_axis_tready <= 1'b0;
      ready_hold    <= $urandom_range(1, 19) - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Every output beat is checked at the edge that accepts it.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_byte(render_byte_t'({m_axis_tdata[7:0], m_axis_tdata[10:8],
                                    m_axis_tdata[17:11]}));
    end
  end

  // The run ends as a failure when neither side has moved a beat for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_count <= 0;
    end else if (quiet_count == QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  function automatic item_t random_beat(input logic [1:0] cmd);
    item_t beat;
    beat.command      = cmd;
    beat.address      = 11'($urandom_range(0, 2047));
    beat.data         = 8'($urandom);
    beat.page_row     = 3'($urandom);
    beat.pixel_column = 7'($urandom);
    return beat;
  endfunction

  // Offers one beat, after a random gap now and then, and waits for its acceptance.
  task automatic send_beat(input item_t beat);
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, beat.pixel_column, beat.page_row, beat.data, beat.address};
    s_axis_tuser  <= beat.command;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_beat(beat);
    if (!(beat.command == CMD_UNUSED ||
          (beat.command == CMD_WRITE_CELL && int'(beat.address) >= FIELD_CELLS))) begin
      live_beats++;
    end
  endtask

  task automatic send_write(input logic [1:0] cmd, input logic [10:0] address,
                            input logic [7:0] value);
    item_t beat;
    beat         = random_beat(cmd);
    beat.address = address;
    beat.data    = value;
    send_beat(beat);
  endtask

  // Makes sure a cell and the pattern byte it points at hold written values.
  task automatic define_cell(input int cell_idx, input int byte_col);
    int pi;
    if (!sb.cell_set[cell_idx]) begin
      send_write(CMD_WRITE_CELL, 11'(cell_idx), 8'($urandom));
    end
    pi = sb.pattern_index(cell_idx, byte_col);
    if (!sb.pattern_set[pi]) begin
      send_write(CMD_WRITE_PATTERN, 11'(pi), 8'($urandom));
    end
  endtask

  task automatic issue_render(input logic [2:0] row, input logic [6:0] column);
    item_t beat;
    int    top;
    int    low;
    int    bc;
    int    ys;
    sb.locate(row, column, top, low, bc, ys);
    define_cell(top, bc);
    if (ys != 0) begin
      define_cell(low, bc);
    end
    beat              = random_beat(CMD_RENDER);
    beat.page_row     = row;
    beat.pixel_column = column;
    send_beat(beat);
  endtask

  // Stops the sender until the pipeline has emptied.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_bytes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_scroll(input logic [7:0] x, input logic [7:0] y);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_SCROLL_X;
    cfg_data_i  <= x;
    @(posedge clk_i);
    cfg_index_i <= REG_SCROLL_Y;
    cfg_data_i  <= y;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.scroll_x = x;
    sb.scroll_y = y;
  endtask

  // One random step: mostly renders, single or as a run of adjacent columns.
  task automatic random_step();
    int       pick;
    int       first;
    int       last;
    logic [2:0] row;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      issue_render(3'($urandom), 7'($urandom));
    end else if (pick < 55) begin
      row   = 3'($urandom);
      first = $urandom_range(0, VIEW_WIDTH_PIXELS - 1);
      last  = first + $urandom_range(3, 15);
      if (last > VIEW_WIDTH_PIXELS - 1) last = VIEW_WIDTH_PIXELS - 1;
      for (int c = first; c <= last; c++) issue_render(row, 7'(c));
    end else if (pick < 70) begin
      send_beat(random_beat(CMD_WRITE_PATTERN));
    end else if (pick < 85) begin
      send_write(CMD_WRITE_CELL, 11'($urandom_range(0, FIELD_CELLS - 1)), 8'($urandom));
    end else if (pick < 93) begin
      // Cell writes past the playfield leave the stores untouched.
      send_write(CMD_WRITE_CELL, 11'($urandom_range(FIELD_CELLS, 2047)), 8'($urandom));
    end else begin
      send_beat(random_beat(CMD_UNUSED));
    end
  endtask

  task automatic run_phase(input logic [7:0] x, input logic [7:0] y,
                           input int gap, input int stall);
    int goal;
    wait_idle();
    write_scroll(x, y);
    gap_odds   = gap;
    stall_odds = stall;
    goal       = live_beats + PHASE_BEATS;
    while (live_beats < goal) random_step();
  endtask

  initial begin
    item_t beat;
    int    top;
    int    low;
    int    bc;
    int    ys;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, first with the scroll registers at their reset values, which
    // puts the view on whole tile rows.
    stall_odds = 8;
    send_write(CMD_WRITE_CELL, 11'h7FF, 8'hFF);
    beat         = random_beat(CMD_UNUSED);
    beat.address = '1;
    beat.data    = '1;
    send_beat(beat);
    send_write(CMD_WRITE_PATTERN, 11'h7FF, 8'hFF);
    send_write(CMD_WRITE_PATTERN, 11'h000, 8'h00);
    // Top-left corner on tile 0, bottom-right corner on the highest tile.
    sb.locate(3'd0, 7'd0, top, low, bc, ys);
    send_write(CMD_WRITE_CELL, 11'(top), 8'h00);
    issue_render(3'd0, 7'd0);
    sb.locate(3'd7, 7'd127, top, low, bc, ys);
    send_write(CMD_WRITE_CELL, 11'(top), 8'hFF);
    issue_render(3'd7, 7'd127);
    issue_render(3'd0, 7'd127);
    issue_render(3'd7, 7'd0);
    send_write(CMD_WRITE_CELL, 11'(FIELD_CELLS - 1), 8'hFF);

    // Both registers at their maximum, with the largest fine offsets, so every byte
    // merges two tile rows.
    wait_idle();
    write_scroll(8'hFF, 8'hFF);
    issue_render(3'd0, 7'd0);
    issue_render(3'd7, 7'd127);
    issue_render(3'd3, 7'd64);

    // Random phases over extreme and random scroll settings.
    run_phase(8'd0,   8'd0,   0,  0);
    run_phase(8'd255, 8'd239, 6,  10);
    run_phase(8'd7,   8'd7,   12, 4);
    run_phase(8'd8,   8'd1,   3,  0);
    run_phase(8'd128, 8'd4,   0,  5);
    run_phase(8'd0,   8'd232, 10, 20);
    run_phase(8'($urandom), 8'($urandom), 5, 8);
    run_phase(8'($urandom), 8'($urandom_range(0, 239)), 20, 3);
    run_phase(8'($urandom), 8'($urandom), 8, 8);
    // The last phase runs without gaps or stalls.
    run_phase(8'($urandom), 8'($urandom), 0, 0);

    wait_idle();
    if (sb.clean()) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
